>>> hdl/a85_pkg.sv
// Shared types and constants for the base-85 stream decoder.
// No dependencies; every other file of the block but the channel interface file imports this package.
package a85_pkg;

    // Result kinds as seen on the output channel
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_OK   = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    // Characters of interest in the encoded stream
    localparam logic [7:0] CH_BANG  = 8'h21;  // digit zero
    localparam logic [7:0] CH_U     = 8'h75;  // digit 84
    localparam logic [7:0] CH_Z     = 8'h7A;  // four zero bytes
    localparam logic [7:0] CH_TILDE = 8'h7E;  // first half of end marker
    localparam logic [7:0] CH_GT    = 8'h3E;  // second half of end marker
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;  // first of the control whitespace run
    localparam logic [7:0] CH_CR    = 8'h0D;  // last of the control whitespace run

    // Arithmetic constants
    localparam logic [19:0] RADIX    = 20'd85;
    localparam logic [19:0] RADIX_P2 = 20'd7225;
    localparam logic [19:0] RADIX_P3 = 20'd614125;
    localparam logic [31:0] PAD_ALL  = 32'h00FF_FFFF;

    // Command queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One queued command: up to four bytes of a word, then an optional status
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        has_tail;
        t_kind       tail_kind;
    } t_cmd;

    // Front to queue write port
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_push;

    // Queue head as seen by the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

endpackage

>>> hdl/a85_stream_if.sv
// Valid/ready channel interfaces for the encoded input and the result output.
// Stand-alone; payload widths follow the block's field list.
interface a85_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       stream_last;

    modport source (output valid, in_byte, stream_last, input ready);
    modport sink   (input valid, in_byte, stream_last, output ready);
endinterface

interface a85_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       run_last;

    modport source (output valid, out_byte, kind, run_last, input ready);
    modport sink   (input valid, out_byte, kind, run_last, output ready);
endinterface

>>> hdl/a85_front.sv
// Front end: accepts encoded beats, keeps the group accumulator and issues commands.
// Depends on a85_pkg and a85_in_if.
module a85_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    a85_in_if.sink            i_in,
    input  logic              i_full,
    output a85_pkg::t_q_push  o_push
);
    import a85_pkg::*;

    logic [31:0] r_sum,      n_sum;
    logic [2:0]  r_count,    n_count;
    logic        r_tilde,    n_tilde;
    logic        r_finished, n_finished;

    logic        w_accept;
    logic [7:0]  w_b;
    logic        w_close;
    logic [19:0] w_factor;
    logic [31:0] w_addend;
    logic [31:0] w_prod;
    logic [31:0] w_sum_next;
    t_cmd        w_cmd;

    assign i_in.ready = !i_full;
    assign w_accept   = i_in.valid && !i_full;
    assign w_b        = i_in.in_byte;
    assign w_close    = r_tilde && (w_b == CH_GT);

    // Pick multiplier and addend: one digit step, or padding of a short group
    always_comb begin
        w_factor = RADIX;
        w_addend = {24'd0, w_b - CH_BANG};
        if (w_close) begin
            case (r_count)
                3'd2:    begin w_factor = RADIX_P3; w_addend = PAD_ALL;       end
                3'd3:    begin w_factor = RADIX_P2; w_addend = PAD_ALL >> 8;  end
                default: begin w_factor = RADIX;    w_addend = PAD_ALL >> 16; end
            endcase
        end
    end

    // Keep the low word of the product only: the sum wraps at 32 bits
    assign w_prod     = r_sum * {12'd0, w_factor};
    assign w_sum_next = w_prod + w_addend;

    // Classify the beat, update stream state and build the command
    always_comb begin
        n_sum      = r_sum;
        n_count    = r_count;
        n_tilde    = r_tilde;
        n_finished = r_finished;
        w_cmd.word      = w_sum_next;
        w_cmd.nbytes    = 3'd0;
        w_cmd.has_tail  = 1'b0;
        w_cmd.tail_kind = KIND_OK;

        if (!r_finished) begin
            if (r_tilde) begin
                n_tilde = 1'b0;
                if (w_b == CH_GT && r_count != 3'd1) begin
                    if (r_count >= 3'd2) begin
                        w_cmd.nbytes = r_count - 3'd1;
                    end
                    w_cmd.has_tail  = 1'b1;
                    w_cmd.tail_kind = KIND_OK;
                    n_sum           = 32'd0;
                    n_count         = 3'd0;
                    n_finished      = 1'b1;
                end else begin
                    w_cmd.has_tail  = 1'b1;
                    w_cmd.tail_kind = KIND_ERR;
                    n_finished      = 1'b1;
                end
            end else if (w_b == CH_TILDE) begin
                if (i_in.stream_last) begin
                    w_cmd.has_tail  = 1'b1;
                    w_cmd.tail_kind = KIND_ERR;
                    n_finished      = 1'b1;
                end else begin
                    n_tilde = 1'b1;
                end
            end else if (w_b >= CH_BANG && w_b <= CH_U) begin
                if (r_count == 3'd4) begin
                    w_cmd.nbytes = 3'd4;
                    n_sum        = 32'd0;
                    n_count      = 3'd0;
                end else begin
                    n_sum   = w_sum_next;
                    n_count = r_count + 3'd1;
                end
            end else if (w_b == CH_Z) begin
                if (r_count != 3'd0) begin
                    w_cmd.has_tail  = 1'b1;
                    w_cmd.tail_kind = KIND_ERR;
                    n_finished      = 1'b1;
                end else begin
                    w_cmd.word   = 32'd0;
                    w_cmd.nbytes = 3'd4;
                end
            end else if (w_b == CH_SPACE || (w_b >= CH_TAB && w_b <= CH_CR)) begin
                // skip whitespace
            end else begin
                w_cmd.has_tail  = 1'b1;
                w_cmd.tail_kind = KIND_ERR;
                n_finished      = 1'b1;
            end

            // End of input without marker: drop the partial group, report done
            if (i_in.stream_last && !n_finished) begin
                w_cmd.has_tail  = 1'b1;
                w_cmd.tail_kind = KIND_OK;
            end
        end

        // Final beat re-arms for the next stream
        if (i_in.stream_last) begin
            n_sum      = 32'd0;
            n_count    = 3'd0;
            n_tilde    = 1'b0;
            n_finished = 1'b0;
        end
    end

    assign o_push.valid = w_accept && (w_cmd.nbytes != 3'd0 || w_cmd.has_tail);
    assign o_push.cmd   = w_cmd;

    // Hold state between beats, advance on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= 32'd0;
            r_count    <= 3'd0;
            r_tilde    <= 1'b0;
            r_finished <= 1'b0;
        end else if (w_accept) begin
            r_sum      <= n_sum;
            r_count    <= n_count;
            r_tilde    <= n_tilde;
            r_finished <= n_finished;
        end
    end

endmodule

>>> hdl/a85_queue.sv
// Short command queue between the front end and the result serialiser.
// Depends on a85_pkg.
module a85_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  a85_pkg::t_q_push  i_push,
    input  logic              i_pop,
    output logic              o_full,
    output a85_pkg::t_q_head  o_head
);
    import a85_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]   r_count,  n_count;
    logic                w_wr;
    logic                w_rd;

    assign o_full      = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];

    assign w_wr = i_push.valid && !o_full;
    assign w_rd = i_pop && o_head.valid;

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = r_wr_ptr + QPTR_W'(1);
        end
        if (w_rd) begin
            n_rd_ptr = r_rd_ptr + QPTR_W'(1);
        end
        case ({w_wr, w_rd})
            2'b10:   n_count = r_count + QCNT_W'(1);
            2'b01:   n_count = r_count - QCNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store command entries
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_push.cmd;
        end
    end

endmodule

>>> hdl/a85_back.sv
// Back end: serialises each queued command into result beats behind an output register.
// Depends on a85_pkg and a85_out_if.
module a85_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  a85_pkg::t_q_head  i_head,
    output logic              o_pop,
    a85_out_if.source         o_out
);
    import a85_pkg::*;

    logic        r_valid, n_valid;
    logic [2:0]  r_pos,   n_pos;
    logic [7:0]  r_byte;
    t_kind       r_kind;
    logic        r_last;

    logic        w_load;
    logic [2:0]  w_total;
    logic        w_is_last;
    logic [7:0]  w_byte;
    t_kind       w_kind;

    assign w_load    = i_head.valid && (!r_valid || o_out.ready);
    assign w_total   = i_head.cmd.nbytes + {2'd0, i_head.cmd.has_tail};
    assign w_is_last = (r_pos + 3'd1 == w_total);

    // Select the beat at the current position: bytes first, status after
    always_comb begin
        w_byte = 8'd0;
        w_kind = i_head.cmd.tail_kind;
        if (r_pos < i_head.cmd.nbytes) begin
            w_kind = KIND_BYTE;
            case (r_pos[1:0])
                2'd0:    w_byte = i_head.cmd.word[31:24];
                2'd1:    w_byte = i_head.cmd.word[23:16];
                2'd2:    w_byte = i_head.cmd.word[15:8];
                default: w_byte = i_head.cmd.word[7:0];
            endcase
        end
    end

    // Advance position, drop the command after its last beat
    always_comb begin
        n_valid = r_valid;
        n_pos   = r_pos;
        if (o_out.ready) begin
            n_valid = 1'b0;
        end
        if (w_load) begin
            n_valid = 1'b1;
            n_pos   = w_is_last ? 3'd0 : r_pos + 3'd1;
        end
    end

    assign o_pop = w_load && w_is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= 3'd0;
        end else begin
            r_valid <= n_valid;
            r_pos   <= n_pos;
        end
    end

    // Hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= w_byte;
            r_kind <= w_kind;
            r_last <= w_is_last;
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.out_byte = r_byte;
    assign o_out.kind     = r_kind;
    assign o_out.run_last = r_last;

endmodule

>>> hdl/ascii85_stream_decoder_core.sv
// Base-85 stream decoder. Throughput: one encoded beat per cycle while the four-entry
// command queue has room; results leave at one per cycle while the output is ready.
// After a beat is accepted, its first result passes through the queue write and then
// the output register load.
// Reset: synchronous, active low; clears stream state, empties the queue and the
// output register. No clearing pass; the block accepts beats right after reset.
module ascii85_stream_decoder_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    a85_in_if.sink    i_in,
    a85_out_if.source o_out
);
    import a85_pkg::*;

    t_q_push w_push;
    t_q_head w_head;
    logic    w_full;
    logic    w_pop;

    a85_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push)
    );

    a85_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_head  (w_head)
    );

    a85_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

>>> verif/testbench.sv
// Self-checking bench for the base-85 stream decoder: directed table, then random streams.
// Depends on a85_pkg, the a85_in_if / a85_out_if channel interfaces and the decoder core.
module testbench;
    import a85_pkg::*;

    localparam int          LIMIT_CYCLES = 200000;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          MAX_REPORTS  = 10;
    localparam logic [7:0]  CH_LF        = 8'h0A;
    localparam logic [7:0]  CH_VT        = 8'h0B;
    localparam logic [7:0]  CH_FF        = 8'h0C;
    localparam logic [31:0] BASE         = 32'd85;

    // How a beat's results are known: from the predictor, or typed into the table
    typedef enum logic [2:0] {
        EXP_MODEL,
        EXP_NONE,
        EXP_ERR,
        EXP_OK,
        EXP_ZERO4
    } t_exp_sel;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        t_exp_sel   sel;
    } t_beat;

    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
        logic       tail;
    } t_result;

    // Directed streams: boundary 'z', full groups, padded close, leftover digit,
    // 'z' inside a group, bad bytes, lone tilde, final byte without marker
    localparam t_beat DIR_TAB [0:24] = '{
        '{CH_Z,     1'b0, EXP_ZERO4},
        '{CH_U,     1'b0, EXP_MODEL},
        '{CH_U,     1'b0, EXP_MODEL},
        '{CH_SPACE, 1'b0, EXP_MODEL},
        '{CH_U,     1'b0, EXP_MODEL},
        '{CH_LF,    1'b0, EXP_MODEL},
        '{CH_U,     1'b0, EXP_MODEL},
        '{CH_U,     1'b0, EXP_MODEL},
        '{CH_BANG,  1'b0, EXP_MODEL},
        '{CH_BANG,  1'b0, EXP_MODEL},
        '{CH_TILDE, 1'b0, EXP_MODEL},
        '{CH_GT,    1'b0, EXP_MODEL},
        '{"A",      1'b1, EXP_NONE},
        '{"5",      1'b0, EXP_MODEL},
        '{CH_TILDE, 1'b0, EXP_MODEL},
        '{CH_GT,    1'b0, EXP_ERR},
        '{CH_Z,     1'b1, EXP_NONE},
        '{"r",      1'b0, EXP_MODEL},
        '{CH_Z,     1'b0, EXP_ERR},
        '{8'hFF,    1'b1, EXP_NONE},
        '{8'h00,    1'b1, EXP_ERR},
        '{CH_TILDE, 1'b1, EXP_ERR},
        '{CH_TILDE, 1'b0, EXP_MODEL},
        '{"a",      1'b1, EXP_ERR},
        '{"B",      1'b1, EXP_OK}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    a85_in_if  in_if ();
    a85_out_if out_if ();

    ascii85_stream_decoder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_beat       enc_feed [$];
    t_result     pending_results [$];
    t_beat       cur_beat;
    t_beat       drv_next;
    t_result     seen_result;
    t_result     want_result;
    int unsigned src_idle_pct  = 0;
    int unsigned snk_stall_pct = 0;
    int unsigned hold_reqs     = 0;
    int unsigned hold_seen     = 0;
    int unsigned hold_left     = 0;
    int unsigned cycle_count   = 0;
    int unsigned mismatches    = 0;

    // Predicted decoder state
    logic [31:0] acc_sum   = '0;
    logic [2:0]  acc_count = '0;
    logic        tilde_seen = 1'b0;
    logic        stream_done = 1'b0;
    t_result     beat_res [5];
    int          beat_nres;

    // Clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void put_result(logic [7:0] data, t_kind kind);
        if (beat_nres < 5) begin
            beat_res[beat_nres] = '{data, kind, 1'b0};
            beat_nres++;
        end
    endfunction

    function automatic void raise_error();
        put_result(8'h00, KIND_ERR);
        stream_done = 1'b1;
    endfunction

    // Close on the end marker: pad a partial group and emit count-1 bytes
    function automatic void close_group();
        logic [31:0] padded;
        int          cnt;
        cnt = acc_count;
        if (cnt == 1) begin
            raise_error();
            return;
        end
        if (cnt >= 2) begin
            padded = acc_sum;
            for (int i = cnt; i < 5; i++)
                padded = padded * BASE;
            padded = padded + (PAD_ALL >> (8 * (cnt - 2)));
            for (int i = 0; i < cnt - 1; i++)
                put_result(8'(padded >> (24 - 8 * i)), KIND_BYTE);
        end
        put_result(8'h00, KIND_OK);
        acc_sum     = '0;
        acc_count   = '0;
        stream_done = 1'b1;
    endfunction

    // Work out the results of one accepted beat and advance the predicted state
    function automatic void decode_beat(logic [7:0] ch, logic last);
        beat_nres = 0;
        if (!stream_done) begin
            if (tilde_seen) begin
                tilde_seen = 1'b0;
                if (ch == CH_GT)
                    close_group();
                else
                    raise_error();
            end else if (ch == CH_TILDE) begin
                if (last)
                    raise_error();
                else
                    tilde_seen = 1'b1;
            end else if (ch >= CH_BANG && ch <= CH_U) begin
                acc_sum   = acc_sum * BASE + 32'(ch - CH_BANG);
                acc_count = acc_count + 3'd1;
                if (acc_count >= 3'd5) begin
                    for (int i = 0; i < 4; i++)
                        put_result(8'(acc_sum >> (24 - 8 * i)), KIND_BYTE);
                    acc_sum   = '0;
                    acc_count = '0;
                end
            end else if (ch == CH_Z) begin
                if (acc_count != 0)
                    raise_error();
                else
                    for (int i = 0; i < 4; i++)
                        put_result(8'h00, KIND_BYTE);
            end else if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) begin
                // skip whitespace
            end else begin
                raise_error();
            end
            if (last && !stream_done)
                put_result(8'h00, KIND_OK);
        end
        // Re-arm on the final byte
        if (last) begin
            acc_sum     = '0;
            acc_count   = '0;
            tilde_seen  = 1'b0;
            stream_done = 1'b0;
        end
        if (beat_nres > 0)
            beat_res[beat_nres - 1].tail = 1'b1;
    endfunction

    function automatic void note_mismatch(t_result want, t_result got, bit have_want);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            if (have_want)
                $display("mismatch: expected %02h/%0d/%0b, got %02h/%0d/%0b",
                         want.data, want.kind, want.tail, got.data, got.kind, got.tail);
            else
                $display("unexpected result: byte %02h kind %0d last %0b",
                         got.data, got.kind, got.tail);
        end
    endfunction

    // Predict on each input beat, then check each output beat against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                decode_beat(in_if.in_byte, in_if.stream_last);
                case (cur_beat.sel)
                    EXP_MODEL: begin
                        for (int i = 0; i < beat_nres; i++)
                            pending_results.push_back(beat_res[i]);
                    end
                    EXP_ERR:  pending_results.push_back('{8'h00, KIND_ERR, 1'b1});
                    EXP_OK:   pending_results.push_back('{8'h00, KIND_OK, 1'b1});
                    EXP_ZERO4: begin
                        for (int i = 0; i < 4; i++)
                            pending_results.push_back('{8'h00, KIND_BYTE, i == 3});
                    end
                    default: ;
                endcase
            end
            if (out_if.valid && out_if.ready) begin
                seen_result = '{out_if.out_byte, t_kind'(out_if.kind), out_if.run_last};
                if (pending_results.size() == 0) begin
                    note_mismatch(seen_result, seen_result, 1'b0);
                end else begin
                    want_result = pending_results.pop_front();
                    if (want_result.data != seen_result.data ||
                        want_result.kind != seen_result.kind ||
                        want_result.tail != seen_result.tail)
                        note_mismatch(want_result, seen_result, 1'b1);
                end
            end
        end
    end

    // Sender: offer the next beat, idling at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_if.ready) begin
            if (enc_feed.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                drv_next = enc_feed.pop_front();
                in_if.valid       <= 1'b1;
                in_if.in_byte     <= drv_next.ch;
                in_if.stream_last <= drv_next.last;
                cur_beat          <= drv_next;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: long hold-off on request, otherwise stall at random
    always @(posedge i_clk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen    <= hold_reqs;
            hold_left    <= HOLD_CYCLES;
            out_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic void add_beat(logic [7:0] ch, logic last);
        enc_feed.push_back('{ch, last, EXP_MODEL});
    endfunction

    function automatic logic [7:0] digit_char();
        int d;
        case ($urandom_range(3))
            0:       d = 0;
            1:       d = 84;
            default: d = $urandom_range(0, 84);
        endcase
        return CH_BANG + 8'(d);
    endfunction

    function automatic logic [7:0] space_char();
        case ($urandom_range(5))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            3:       return CH_VT;
            4:       return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    // One encoded stream: mostly well-formed with random content, the rest noise
    function automatic void gen_stream();
        int ngrp;
        int npart;
        int len;
        if ($urandom_range(99) < 72) begin
            ngrp = $urandom_range(0, 3);
            for (int g = 0; g < ngrp; g++) begin
                if ($urandom_range(4) == 0) begin
                    add_beat(CH_Z, 1'b0);
                end else begin
                    for (int d = 0; d < 5; d++) begin
                        // corrupt a digit now and then
                        if ($urandom_range(39) == 0)
                            add_beat(8'($urandom_range(255)), 1'b0);
                        else
                            add_beat(digit_char(), 1'b0);
                        if ($urandom_range(7) == 0)
                            add_beat(space_char(), 1'b0);
                    end
                end
            end
            npart = $urandom_range(0, 4);
            for (int d = 0; d < npart; d++)
                add_beat(digit_char(), 1'b0);
            case ($urandom_range(3))
                0: begin
                    add_beat(CH_TILDE, 1'b0);
                    add_beat(CH_GT, 1'b0);
                    add_beat(8'($urandom_range(255)), 1'b1);
                end
                1: begin
                    add_beat(CH_TILDE, 1'b0);
                    add_beat(CH_GT, 1'b1);
                end
                2:       add_beat(digit_char(), 1'b1);
                default: add_beat(space_char(), 1'b1);
            endcase
        end else begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
                add_beat(((i % 3 == 1) && $urandom_range(1)) ? CH_TILDE
                                                           : 8'($urandom_range(255)),
                         i == len - 1);
        end
    endfunction

    task automatic run_random(int unsigned idle_pct, int unsigned stall_pct,
                              bit with_hold, int nbeats);
        int target;
        @(negedge i_clk);
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        if (with_hold)
            hold_reqs++;
        target = enc_feed.size() + nbeats;
        while (enc_feed.size() < target)
            gen_stream();
        while (enc_feed.size() != 0 || in_if.valid)
            @(posedge i_clk);
    endtask

    initial begin
        in_if.valid       = 1'b0;
        in_if.in_byte     = 8'h00;
        in_if.stream_last = 1'b0;
        out_if.ready      = 1'b0;
        cur_beat          = '{8'h00, 1'b0, EXP_MODEL};

        // Hold reset, then release
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, no idling
        @(negedge i_clk);
        foreach (DIR_TAB[i])
            enc_feed.push_back(DIR_TAB[i]);
        while (enc_feed.size() != 0 || in_if.valid)
            @(posedge i_clk);

        // Random streams under each idling mix; the first backs up the output
        run_random(0, 0, 1'b1, 85);
        run_random(59, 0, 1'b0, 85);
        run_random(0, 59, 1'b0, 85);
        run_random(14, 14, 1'b0, 85);

        // Drain
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
